FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define LPPE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define LPPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lppe_pkg.sv
package lppe_pkg;

  localparam int PKT_LEN     = 36;
  localparam int HDR_LEN     = 4;
  localparam int ADDR_W      = $clog2(PKT_LEN);
  localparam int CNT_W       = 6;
  localparam int START_OFF   = 6;
  localparam int END_OFF     = 32;
  localparam int RD_FIRST    = 8;
  localparam int PT_STRIDE   = 3;
  localparam int NUM_PTS     = 8;
  localparam int K_W         = $clog2(NUM_PTS);
  localparam int ANG_FULL    = 360;
  localparam int RAW_ZERO    = 40960;
  localparam int RAW_MIN     = 40897;
  localparam int RAW_LIMIT   = 64000;
  localparam int RECIP7      = 4681;
  localparam int RECIP_SHIFT = 15;

  localparam logic [7:0] SYNC_SEQ [HDR_LEN] = '{8'h55, 8'hAA, 8'h03, 8'h08};

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic       ok;
    logic [8:0] deg;
  } ang_t;

  typedef struct packed {
    logic       valid;
    logic [8:0] start_deg;
    logic [9:0] delta;
  } sweep_t;

  function automatic ang_t angle_from_raw(input logic [15:0] raw);
    ang_t       a;
    logic [15:0] diff;
    diff  = raw - 16'(RAW_ZERO);
    a.ok  = (raw >= 16'(RAW_MIN)) && (raw < 16'(RAW_LIMIT));
    a.deg = (raw >= 16'(RAW_ZERO)) ? diff[14:6] : 9'd0;
    return a;
  endfunction

endpackage

FILE: rtl/lppe_pkt_store.sv
module lppe_pkt_store
  import lppe_pkg::*;
(
  input  logic              clk,
  input  wr_t               wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr_lo,
  input  logic [ADDR_W-1:0] rd_addr_hi,
  output logic [7:0]        rd_lo,
  output logic [7:0]        rd_hi
);

  logic [7:0] mem [PKT_LEN];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lo <= mem[rd_addr_lo];
      rd_hi <= mem[rd_addr_hi];
    end
  end

endmodule

FILE: rtl/lppe_parser.sv
`include "assert_macros.svh"

module lppe_parser
  import lppe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] rx_byte,
  input  logic       busy,
  output wr_t        wr,
  output sweep_t     sweep
);

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] count, count_next;
  logic [7:0]       lo;
  ang_t             a0, a1;
  logic             acc;

  assign byte_stall = busy && (phase == PH_BODY) && (count >= CNT_W'(RD_FIRST));
  assign acc        = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (phase == PH_BODY)) begin
      case (count)
        CNT_W'(START_OFF), CNT_W'(END_OFF): lo <= rx_byte;
        CNT_W'(START_OFF + 1):              a0 <= angle_from_raw({rx_byte, lo});
        CNT_W'(END_OFF + 1):                a1 <= angle_from_raw({rx_byte, lo});
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next      = phase;
    count_next      = count;
    wr.en           = 1'b0;
    wr.addr         = count[ADDR_W-1:0];
    wr.data         = rx_byte;
    sweep.valid     = 1'b0;
    sweep.start_deg = a0.deg;
    sweep.delta     = (a1.deg >= a0.deg) ? ({1'b0, a1.deg} - {1'b0, a0.deg})
                                         : ({1'b0, a1.deg} + 10'(ANG_FULL) - {1'b0, a0.deg});
    unique case (phase)
      PH_HDR: begin
        if (acc) begin
          if (rx_byte == SYNC_SEQ[count[1:0]]) begin
            wr.en      = 1'b1;
            count_next = count + CNT_W'(1);
            if (count == CNT_W'(HDR_LEN - 1)) begin
              phase_next = PH_BODY;
            end
          end else begin
            count_next = '0;
            phase_next = PH_WAIT;
          end
        end
      end
      PH_BODY: begin
        if (acc) begin
          wr.en = 1'b1;
          if (count == CNT_W'(PKT_LEN - 1)) begin
            sweep.valid = a0.ok && a1.ok;
            count_next  = '0;
            phase_next  = PH_WAIT;
          end else begin
            count_next = count + CNT_W'(1);
          end
        end
      end
      default: begin
        if (acc) begin
          if (rx_byte == SYNC_SEQ[0]) begin
            wr.en      = 1'b1;
            wr.addr    = '0;
            count_next = CNT_W'(1);
            phase_next = PH_HDR;
          end else begin
            count_next = '0;
            phase_next = PH_WAIT;
          end
        end
      end
    endcase
  end

  `LPPE_ASSERT(a_wr_below_reads, !(busy && wr.en) || (wr.addr < ADDR_W'(RD_FIRST)), "write hits unread point data")
  `LPPE_ASSERT(a_sweep_on_last, !sweep.valid || (wr.en && (wr.addr == ADDR_W'(PKT_LEN - 1))), "sweep without completing byte")

endmodule

FILE: rtl/lppe_point_gen.sv
`include "assert_macros.svh"

module lppe_point_gen
  import lppe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  sweep_t            sweep,
  output logic              busy,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr_lo,
  output logic [ADDR_W-1:0] rd_addr_hi,
  input  logic [7:0]        rd_lo,
  input  logic [7:0]        rd_hi,
  output logic              point_valid,
  input  logic              point_stall,
  output logic [8:0]        angle_deg,
  output logic [15:0]       range_raw,
  output logic              last_point
);

  logic [8:0]     base;
  logic [9:0]     delta;
  logic [12:0]    acc;
  logic [K_W-1:0] k;
  logic           s1_valid, s1_last;
  logic [8:0]     s1_angle;
  logic           out_free, issue;
  logic [25:0]    prod;
  logic [9:0]     q, sum;
  logic [8:0]     ang;

  assign out_free   = !point_valid || !point_stall;
  assign issue      = busy && (!s1_valid || out_free);
  assign rd_en      = issue;
  assign rd_addr_lo = ADDR_W'(RD_FIRST) + ADDR_W'({k, 1'b0}) + ADDR_W'(k);
  assign rd_addr_hi = rd_addr_lo + ADDR_W'(1);

  assign prod = (26'(acc) + 26'd1) * 26'(RECIP7);
  assign q    = prod[RECIP_SHIFT +: 10];
  assign sum  = {1'b0, base} + q;
  assign ang  = (sum >= 10'(ANG_FULL)) ? 9'(sum - 10'(ANG_FULL)) : sum[8:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      s1_valid    <= 1'b0;
      point_valid <= 1'b0;
    end else begin
      if (sweep.valid) begin
        busy <= 1'b1;
      end else if (issue && (k == K_W'(NUM_PTS - 1))) begin
        busy <= 1'b0;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
      if (out_free) begin
        point_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweep.valid) begin
      base  <= sweep.start_deg;
      delta <= sweep.delta;
      acc   <= '0;
      k     <= '0;
    end else if (issue) begin
      acc <= acc + 13'(delta);
      k   <= k + K_W'(1);
    end
    if (issue) begin
      s1_angle <= ang;
      s1_last  <= (k == K_W'(NUM_PTS - 1));
    end
    if (out_free) begin
      angle_deg  <= s1_angle;
      range_raw  <= {rd_hi, rd_lo};
      last_point <= s1_last;
    end
  end

  `LPPE_ASSERT(a_no_sweep_busy, !(sweep.valid && busy), "new sweep while points pending")
  `LPPE_ASSERT(a_rd_in_range, !issue || (rd_addr_hi < ADDR_W'(PKT_LEN)), "point read out of range")
  `LPPE_ASSERT_NEXT(a_busy_ends, issue && (k == K_W'(NUM_PTS - 1)), !busy, "sweep did not end on last point")

endmodule

FILE: rtl/lidar_packet_point_extractor_unit.sv
// Takes one byte per cycle; stalls bytes only when a new packet reaches byte 8
// while the previous packet's points are still being read from the store.
// The first point passes the sweep registers, the read stage and the output
// register; then one point per cycle while the receiver does not stall: 8 points per packet.
// Reset clears the header hunt, byte count and point sequencer; the packet
// store is not cleared, every entry is written before it is read.
module lidar_packet_point_extractor_unit
  import lppe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  output logic        point_valid,
  input  logic        point_stall,
  output logic [8:0]  angle_deg,
  output logic [15:0] range_raw,
  output logic        last_point
);

  wr_t               wr;
  sweep_t            sweep;
  logic              busy;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr_lo, rd_addr_hi;
  logic [7:0]        rd_lo, rd_hi;

  lppe_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .rx_byte    (rx_byte),
    .busy       (busy),
    .wr         (wr),
    .sweep      (sweep)
  );

  lppe_pkt_store u_store (
    .clk        (clk),
    .wr         (wr),
    .rd_en      (rd_en),
    .rd_addr_lo (rd_addr_lo),
    .rd_addr_hi (rd_addr_hi),
    .rd_lo      (rd_lo),
    .rd_hi      (rd_hi)
  );

  lppe_point_gen u_point_gen (
    .clk         (clk),
    .rst         (rst),
    .sweep       (sweep),
    .busy        (busy),
    .rd_en       (rd_en),
    .rd_addr_lo  (rd_addr_lo),
    .rd_addr_hi  (rd_addr_hi),
    .rd_lo       (rd_lo),
    .rd_hi       (rd_hi),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .angle_deg   (angle_deg),
    .range_raw   (range_raw),
    .last_point  (last_point)
  );

endmodule
